FILE: sv/crcfc_pkg.sv
// shared types, constants and crc helper for the crc frame checker
package crcfc_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int CNT_W           = 7;
  localparam logic [CNT_W-1:0] CNT_MAX  = 7'd127;
  localparam logic [CNT_W-1:0] OVERHEAD = 7'd8;
  localparam logic [CNT_W-1:0] HDR_LEN  = 7'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [23:0] TAIL_WORD = 24'hBABBBC;
  localparam logic [7:0]  HDR_B0 = 8'hAA;
  localparam logic [7:0]  HDR_B1 = 8'hAB;
  localparam logic [7:0]  HDR_B2 = 8'hAC;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_SHORT    = 3'd1,
    STS_BAD_HDR  = 3'd2,
    STS_BAD_TAIL = 3'd3,
    STS_BAD_CRC  = 3'd4,
    STS_LONG     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_RUN,
    S_CHECK,
    S_DRAIN,
    S_STAT
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } crcfc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       out_last;
    status_t    status;
  } crcfc_out_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // input transaction this cycle
    logic check;     // evaluate the frame and restart
    logic rd_first;  // read first stored payload byte
    logic rd_next;   // advance to next stored payload byte
    logic show_data; // result is a payload byte
  } crcfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic good;       // frame passed every check
    logic drain_last; // current payload byte is the final one
  } crcfc_sts_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = HDR_B0;
      2'd1:    b = HDR_B1;
      default: b = HDR_B2;
    endcase
    return b;
  endfunction

  // crc-16 ccitt, msb first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = b[7-k] ^ c[15];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/crcfc_ctrl.sv
// frame checker controller: accept, check, drain and status states
module crcfc_ctrl
  import crcfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  crcfc_sts_t sts,
  output crcfc_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd.show_data = (state_r == S_DRAIN);
    unique case (state_r)
      S_RUN: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.good) begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_DRAIN;
        end else begin
          state_nxt = S_STAT;
        end
      end
      S_DRAIN: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.drain_last) begin
            state_nxt = S_RUN;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      S_STAT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall))
    else $error("input taken while a result is pending");

  a_check_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |=> state_r != S_CHECK)
    else $error("check state held more than one cycle");

  a_drain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && out_stall) |=> state_r == S_DRAIN)
    else $error("drain left while result stalled");

  a_last_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> state_r == S_CHECK)
    else $error("final byte did not start the check");
`endif

endmodule

FILE: sv/crcfc_dp.sv
// frame checker datapath: window, crc, counters, payload store and result fields
module crcfc_dp
  import crcfc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  crcfc_in_t  in_data,
  input  crcfc_cmd_t cmd,
  output crcfc_sts_t sts,
  output crcfc_out_t out_data
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [CNT_W-1:0] MAX_P = CNT_W'(MAX_PAYLOAD);

  logic [7:0]       mem [MAX_PAYLOAD];
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      crc_r;
  logic [39:0]      win_r;
  logic             hdr_good_r;
  status_t          status_r;
  logic [AW-1:0]    rd_idx_r;
  logic [AW-1:0]    last_idx_r;
  logic [7:0]       rdata_r;

  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] pay_len;
  logic [7:0]       leaving;
  logic             wr_en;
  logic [AW-1:0]    rd_addr;
  status_t          verdict;

  assign leaving = win_r[39:32];
  assign pos     = cnt_r - OVERHEAD;
  assign pay_len = cnt_r - OVERHEAD;
  assign wr_en   = cmd.take && (cnt_r >= OVERHEAD) && (pos < MAX_P);
  assign rd_addr = cmd.rd_first ? '0 : rd_idx_r + AW'(1);

  // checks in priority order
  always_comb begin
    if (cnt_r <= OVERHEAD) begin
      verdict = STS_SHORT;
    end else if (pay_len > MAX_P) begin
      verdict = STS_LONG;
    end else if (!hdr_good_r) begin
      verdict = STS_BAD_HDR;
    end else if (win_r[23:0] != TAIL_WORD) begin
      verdict = STS_BAD_TAIL;
    end else if (win_r[39:32] != crc_r[7:0] || win_r[31:24] != crc_r[15:8]) begin
      verdict = STS_BAD_CRC;
    end else begin
      verdict = STS_OK;
    end
  end

  assign sts.good       = (verdict == STS_OK);
  assign sts.drain_last = (rd_idx_r == last_idx_r);

  // frame tracking
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.check) begin
      cnt_r      <= '0;
      crc_r      <= CRC_INIT;
      win_r      <= '0;
      hdr_good_r <= 1'b1;
    end else if (cmd.take) begin
      if (cnt_r < HDR_LEN) begin
        if (in_data.in_byte != hdr_byte(cnt_r[1:0])) begin
          hdr_good_r <= 1'b0;
        end
      end else if (cnt_r >= OVERHEAD) begin
        crc_r <= crc_feed(crc_r, leaving);
      end
      win_r <= {win_r[31:0], in_data.in_byte};
      if (cnt_r < CNT_MAX) begin
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

  // verdict and drain bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      status_r   <= verdict;
      last_idx_r <= AW'(pay_len - 7'd1);
    end
    if (cmd.rd_first) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_next) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos[AW-1:0]] <= leaving;
    end
    if (cmd.rd_first || cmd.rd_next) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    if (cmd.show_data) begin
      out_data.out_byte = rdata_r;
      out_data.has_data = 1'b1;
      out_data.out_last = sts.drain_last;
      out_data.status   = STS_OK;
    end else begin
      out_data.out_byte = '0;
      out_data.has_data = 1'b0;
      out_data.out_last = 1'b1;
      out_data.status   = status_r;
    end
  end

endmodule

FILE: sv/crc_frame_checker.sv
// crc frame checker top level: controller plus datapath
//
// takes a frame one byte per transaction (in_last on the final byte): header
// AA AB AC, payload, crc-16/ccitt-false of the payload stored low byte first,
// then tail BA BB BC. after the final byte the controller passes through its
// check state; a good frame then returns its payload bytes one per cycle while
// the result channel is not stalled, from the payload store (registered read,
// next address issued as each result is taken), the last one marked, and a bad
// frame returns one status transaction (too short, too long, bad header, bad
// tail, bad crc, in that priority). no input is taken while results are out.
// payloads longer than MAX_PAYLOAD are reported too long; the store is never
// read beyond what the current frame wrote, so it needs no clearing after reset
module crc_frame_checker
  import crcfc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  crcfc_in_t  in_data,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output crcfc_out_t out_data
);

  // command and status between controller and datapath
  crcfc_cmd_t cmd;
  crcfc_sts_t sts;

  // sequences accept, check, drain and status states
  crcfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // window, crc, byte count, payload store and result fields
  crcfc_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

FILE: dv/crc_frame_checker_test.sv
// self-checking testbench for the crc frame checker: directed frames, back-pressure, random frames
module crc_frame_checker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import crcfc_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no transaction on either side
  localparam int SETTLE      = 16;    // check cycle plus registered read, with margin
  localparam logic [23:0] HEAD_WORD = {HDR_B0, HDR_B1, HDR_B2};

  typedef enum int {FLAW_NONE, FLAW_HEADER, FLAW_TAIL, FLAW_CRC} flaw_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  crcfc_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  crcfc_out_t out_data;

  logic hold_off = 1'b0;  // long receiver hold-off
  logic calm = 1'b0;      // no random idling on either side

  always #10 clk = ~clk;

  crc_frame_checker uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  // receive-side state of the frame under way
  logic [7:0]  rx_store [MAX_PAYLOAD_DEF];
  logic [6:0]  rx_count = '0;
  logic [15:0] rx_crc = CRC_INIT;
  logic [39:0] rx_window = '0;
  logic        rx_hdr_ok = 1'b1;

  crcfc_out_t due_results[$];
  logic [7:0] frame_buf[$];

  int mismatches = 0;
  int bytes_in = 0;
  int results_checked = 0;
  int frames_good = 0;
  int frames_rejected = 0;

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic restart_frame();
    rx_count  = '0;
    rx_crc    = CRC_INIT;
    rx_window = '0;
    rx_hdr_ok = 1'b1;
  endtask

  task automatic reject_frame(input status_t code);
    crcfc_out_t item;
    item.out_byte = 8'h00;
    item.has_data = 1'b0;
    item.out_last = 1'b1;
    item.status   = code;
    due_results.push_back(item);
    frames_rejected++;
    restart_frame();
  endtask

  // expected results for one accepted input byte
  task automatic predict_frame_byte(input logic [7:0] b, input logic last);
    logic [6:0] pos;
    logic [7:0] leaving;
    int n;
    crcfc_out_t item;
    if (rx_count < HDR_LEN) begin
      if (b != HEAD_WORD[23 - 8 * rx_count -: 8]) begin
        rx_hdr_ok = 1'b0;
      end
    end else if (rx_count >= OVERHEAD) begin
      // oldest window byte is now known to be payload
      leaving = rx_window[39:32];
      pos = rx_count - OVERHEAD;
      rx_crc = crc16_next(rx_crc, leaving);
      if (pos < MAX_PAYLOAD_DEF) begin
        rx_store[pos[5:0]] = leaving;
      end
    end
    rx_window = {rx_window[31:0], b};
    if (rx_count != CNT_MAX) begin
      rx_count++;
    end
    if (!last) begin
      return;
    end
    n = int'(rx_count) - int'(OVERHEAD);
    if (rx_count <= OVERHEAD) begin
      reject_frame(STS_SHORT);
    end else if (n > MAX_PAYLOAD_DEF) begin
      reject_frame(STS_LONG);
    end else if (!rx_hdr_ok) begin
      reject_frame(STS_BAD_HDR);
    end else if (rx_window[23:0] != TAIL_WORD) begin
      reject_frame(STS_BAD_TAIL);
    end else if ({rx_window[31:24], rx_window[39:32]} != rx_crc) begin
      reject_frame(STS_BAD_CRC);
    end else begin
      for (int i = 0; i < n; i++) begin
        item.out_byte = rx_store[i];
        item.has_data = 1'b1;
        item.out_last = (i == n - 1);
        item.status   = STS_OK;
        due_results.push_back(item);
      end
      frames_good++;
      restart_frame();
    end
  endtask

  // one input transaction, with a random gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    crcfc_in_t item;
    item.in_byte = b;
    item.in_last = last;
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_frame_byte(b, last);
    bytes_in++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  // well-formed frame of n payload bytes; fill < 0 means random content
  task automatic build_frame(input int n, input int fill);
    logic [15:0] crc;
    logic [7:0] b;
    frame_buf = {};
    crc = CRC_INIT;
    frame_buf.push_back(HDR_B0);
    frame_buf.push_back(HDR_B1);
    frame_buf.push_back(HDR_B2);
    for (int i = 0; i < n; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      frame_buf.push_back(b);
      crc = crc16_next(crc, b);
    end
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
    frame_buf.push_back(TAIL_WORD[23:16]);
    frame_buf.push_back(TAIL_WORD[15:8]);
    frame_buf.push_back(TAIL_WORD[7:0]);
  endtask

  // flip bits in one byte of the chosen region of frame_buf
  task automatic corrupt_frame(input flaw_t flaw);
    int last_idx;
    logic [7:0] flip;
    last_idx = frame_buf.size() - 1;
    flip = 8'($urandom_range(1, 255));
    case (flaw)
      FLAW_HEADER: begin
        frame_buf[$urandom_range(2)] ^= flip;
      end
      FLAW_TAIL: begin
        frame_buf[last_idx - $urandom_range(2)] ^= flip;
      end
      FLAW_CRC: begin
        frame_buf[last_idx - 3 - $urandom_range(1)] ^= flip;
      end
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained();
    while (due_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_good_frames();
    build_frame(1, 8'hFF);
    send_frame();
  endtask

  task automatic test_short_frames();
    // no payload at all: short outranks a bad header
    build_frame(0, -1);
    corrupt_frame(FLAW_HEADER);
    send_frame();
  endtask

  task automatic test_bad_header();
    // header outranks tail
    build_frame(1, -1);
    corrupt_frame(FLAW_HEADER);
    corrupt_frame(FLAW_TAIL);
    send_frame();
  endtask

  task automatic test_bad_tail();
    // tail outranks crc
    build_frame(1, -1);
    corrupt_frame(FLAW_TAIL);
    corrupt_frame(FLAW_CRC);
    send_frame();
  endtask

  task automatic test_bad_crc();
    build_frame(1, -1);
    corrupt_frame(FLAW_CRC);
    send_frame();
  endtask

  task automatic test_too_long();
    // one byte over the store, sent with no idling; long outranks header
    calm <= 1'b1;
    build_frame(MAX_PAYLOAD_DEF + 1, -1);
    corrupt_frame(FLAW_HEADER);
    send_frame();
    calm <= 1'b0;
  endtask

  // receiver holds off while frames keep coming, so the input backs up
  task automatic test_backpressure();
    hold_off <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    // full store, then a frame that waits behind those results
    build_frame(MAX_PAYLOAD_DEF, -1);
    send_frame();
    build_frame(1, -1);
    send_frame();
  endtask

  task automatic test_random();
    int start;
    int pick;
    int n;
    int len;
    start = bytes_in;
    while (bytes_in - start < 24) begin
      pick = $urandom_range(99);
      n = $urandom_range(1, 4);
      if (pick < 70) begin
        build_frame(n, -1);
        if ($urandom_range(99) < 35) begin
          corrupt_frame(flaw_t'($urandom_range(FLAW_HEADER, FLAW_CRC)));
        end
        send_frame();
      end else if (pick < 85) begin
        // noise: random bytes, random frame ends
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom), (i == len - 1) || ($urandom_range(7) == 0));
        end
      end else begin
        // truncated frame
        build_frame(n, -1);
        repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
        send_frame();
      end
    end
  endtask

  // receiver: random stall, and check of every accepted result
  always @(posedge clk) begin
    if (rst_n && out_fire) begin
      check_result(out_data);
    end
    out_stall <= hold_off || (!calm && $urandom_range(99) < 15);
  end

  task automatic check_result(input crcfc_out_t got);
    crcfc_out_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = due_results.pop_front();
    if (got.out_byte !== want.out_byte) begin
      report_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
    end
    if (got.has_data !== want.has_data) begin
      report_mismatch($sformatf("has_data %b, expected %b", got.has_data, want.has_data));
    end
    if (got.out_last !== want.out_last) begin
      report_mismatch($sformatf("out_last %b, expected %b", got.out_last, want.out_last));
    end
    if (got.status !== want.status) begin
      report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    end
    results_checked++;
  endtask

  // watchdog: ends the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      quiet = (in_fire || out_fire) ? 0 : quiet + 1;
    end
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_frames();
    test_short_frames();
    test_bad_header();
    test_bad_tail();
    test_bad_crc();
    test_too_long();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (due_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    end
    $display("covered %0d input bytes in %0d frames: %0d good, %0d rejected",
             bytes_in, frames_good + frames_rejected, frames_good, frames_rejected);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
